FILE: design/tcce_pkg.sv
// Shared constants, command codes and state type of the text console cell engine.
`timescale 1ns / 1ps
package tcce_pkg;
	localparam int PAGES_DEF    = 8;
	localparam int ROWS_DEF     = 25;
	localparam int MAX_COLS_DEF = 80;

	localparam int CMD_W  = 3;
	localparam int PAGE_W = 3;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int CNT_W  = 16;
	localparam int LINE_W = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	localparam logic [CMD_W-1:0] CMD_TTY      = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REP_STAY = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REP_MOVE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SET_CUR  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_GET_CUR  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_READ     = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SC_UP    = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SC_DOWN  = 3'd7;

	localparam logic [7:0] CH_BELL  = 8'h07;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] ATTR_REP = 8'h0f;

	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_PAGE = 1'd1;
	localparam logic [COL_W-1:0]     COLUMNS_RST     = 7'd80;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PUT,
		ST_SC_CELL,
		ST_SC_WR,
		ST_RD,
		ST_RD_W,
		ST_DONE
	} state_t;
endpackage

FILE: design/tcce_if.sv
// Handshake interfaces: command items, result items and register writes.
`timescale 1ns / 1ps
interface tcce_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [tcce_pkg::CMD_W-1:0]    cmd;
	logic [tcce_pkg::PAGE_W-1:0]   page;
	logic [7:0]                    char_code;
	logic [7:0]                    attr;
	logic [tcce_pkg::CNT_W-1:0]    count;
	logic [tcce_pkg::ROW_W-1:0]    cur_row;
	logic [tcce_pkg::COL_W-1:0]    cur_col;
	logic [tcce_pkg::ROW_W-1:0]    win_top;
	logic [tcce_pkg::COL_W-1:0]    win_left;
	logic [tcce_pkg::ROW_W-1:0]    win_bottom;
	logic [tcce_pkg::COL_W-1:0]    win_right;
	logic [tcce_pkg::LINE_W-1:0]   scroll_lines;
	modport source (output valid, cmd, page, char_code, attr, count, cur_row, cur_col,
		win_top, win_left, win_bottom, win_right, scroll_lines, input ready);
	modport sink (input valid, cmd, page, char_code, attr, count, cur_row, cur_col,
		win_top, win_left, win_bottom, win_right, scroll_lines, output ready);
endinterface

interface tcce_res_if;
	logic                        valid;
	logic                        ready;
	logic [tcce_pkg::ROW_W-1:0]  out_row;
	logic [tcce_pkg::COL_W-1:0]  out_col;
	logic [7:0]                  out_char;
	logic [7:0]                  out_attr;
	modport source (output valid, out_row, out_col, out_char, out_attr, input ready);
	modport sink (input valid, out_row, out_col, out_char, out_attr, output ready);
endinterface

interface tcce_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [tcce_pkg::CFG_IDX_W-1:0]    index;
	logic [tcce_pkg::CFG_DATA_W-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: design/text_console_cell_engine.sv
// Text console cell engine: cell store, cursors, command sequencer.
`timescale 1ns / 1ps
// Teletype and repeat commands take one character per cycle, except while a line feed on the
// last row scrolls the page. Scroll fills a cell with a write and copies a cell with a
// registered read then a write; a line feed on the last row scrolls the full page this way.
// One command is worked at a time; the next is taken while the last result waits in the
// output register. Reset sets the cursors (page 0 row to ROW_RST) and the registers at once,
// then a clearing pass zeroes the PAGES*ROWS*MAX_COLS cells; no command is taken meanwhile.
module text_console_cell_engine #(
	parameter int PAGES    = tcce_pkg::PAGES_DEF,
	parameter int ROWS     = tcce_pkg::ROWS_DEF,
	parameter int MAX_COLS = tcce_pkg::MAX_COLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tcce_cmd_if.sink    cmd_in,
	tcce_res_if.source  res_out,
	tcce_cfg_if.sink    cfg
);
	localparam int DEPTH  = PAGES * ROWS * MAX_COLS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PG_CELLS = ROWS * MAX_COLS;
	localparam int RW = tcce_pkg::ROW_W;
	localparam int CW = tcce_pkg::COL_W;
	localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
	localparam logic [RW-1:0] ROW_RST  = RW'((ROWS > 5) ? 5 : (ROWS - 1));
	localparam logic [CW:0]   COLS_MAX = (CW + 1)'(MAX_COLS);

	// store with one write port and one registered read port
	logic [15:0]       mem [DEPTH];
	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa, mem_ra;
	logic [15:0]       mem_wd, mem_rd_q;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		mem_rd_q <= mem[mem_ra];
	end

	function automatic logic [ADDR_W-1:0] cell_addr(logic [tcce_pkg::PAGE_W-1:0] p,
		logic [RW-1:0] r, logic [CW-1:0] c);
		cell_addr = ADDR_W'(p * PG_CELLS + r * MAX_COLS + c);
	endfunction

	function automatic logic [tcce_pkg::PAGE_W-1:0] page_sel(logic [tcce_pkg::PAGE_W-1:0] p);
		page_sel = ({1'b0, p} >= (tcce_pkg::PAGE_W + 1)'(PAGES)) ?
			tcce_pkg::PAGE_W'(PAGES - 1) : p;
	endfunction

	// configuration
	logic [CW-1:0]               columns_q;
	logic [tcce_pkg::PAGE_W-1:0] act_page_q;
	logic [CW:0]                 ec, ec_m1;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q  <= tcce_pkg::COLUMNS_RST;
			act_page_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				tcce_pkg::REG_COLUMNS:     columns_q  <= cfg.data;
				tcce_pkg::REG_ACTIVE_PAGE: act_page_q <= cfg.data[tcce_pkg::PAGE_W-1:0];
				default: ;
			endcase
		end
	end

	// effective column count: 0 acts as 1, wider than the store clamps
	always_comb begin
		ec = {1'b0, columns_q};
		if (ec == '0)
			ec = (CW + 1)'(1);
		if (ec > COLS_MAX)
			ec = COLS_MAX;
		ec_m1 = ec - (CW + 1)'(1);
	end

	// cursors per page
	logic [RW-1:0] row_q [PAGES];
	logic [CW-1:0] col_q [PAGES];

	// command registers
	tcce_pkg::state_t            st_q, st_d;
	logic [ADDR_W-1:0]           clr_q;
	logic [tcce_pkg::CMD_W-1:0]  cmd_q;
	logic [tcce_pkg::PAGE_W-1:0] pg_q;
	logic [7:0]                  ch_q, at_q;
	logic [tcce_pkg::CNT_W-1:0]  cnt_q;
	logic                        move_q;
	logic [RW-1:0]               cr_q;
	logic [CW-1:0]               cc_q;
	logic [7:0]                  rd_ch_q, rd_at_q;

	// scroll walker
	logic [tcce_pkg::PAGE_W-1:0] e_pg_q;
	logic [RW-1:0]               e_r_q, e_top_q, e_bot_q, e_n_q;
	logic [CW-1:0]               e_c_q, e_left_q, e_right_q;
	logic                        e_up_q, e_blank_q, e_ret_q;
	logic [15:0]                 e_fill_q;

	// output register
	logic          o_valid_q;
	logic [RW-1:0] o_row_q;
	logic [CW-1:0] o_col_q;
	logic [7:0]    o_char_q, o_attr_q;

	logic accept, load_out;
	assign cmd_in.ready = (st_q == tcce_pkg::ST_IDLE);
	assign accept       = cmd_in.valid && cmd_in.ready;
	assign load_out     = (st_q == tcce_pkg::ST_DONE) && (!o_valid_q || res_out.ready);

	// scroll window of the incoming command, clamped
	logic [RW-1:0] w_bot;
	logic [CW-1:0] w_right;
	logic          w_empty, w_blank;
	logic [RW:0]   w_h;
	always_comb begin
		w_bot   = (cmd_in.win_bottom > ROW_LAST) ? ROW_LAST : cmd_in.win_bottom;
		w_right = ({1'b0, cmd_in.win_right} > ec_m1) ? ec_m1[CW-1:0] : cmd_in.win_right;
		w_empty = (cmd_in.win_top > w_bot) || (cmd_in.win_left > w_right);
		w_h     = {1'b0, w_bot} - {1'b0, cmd_in.win_top} + (RW + 1)'(1);
		w_blank = (cmd_in.scroll_lines == '0) ||
			({{(tcce_pkg::LINE_W - RW - 1){1'b0}}, w_h} <= cmd_in.scroll_lines);
	end

	// walker position
	logic          e_copy, e_last_c, e_last_r;
	logic [RW-1:0] e_src;
	logic [RW:0]   e_sum;
	always_comb begin
		e_sum = {1'b0, e_r_q} + {1'b0, e_n_q};
		if (e_up_q) begin
			e_copy = !e_blank_q && (e_sum <= {1'b0, e_bot_q});
			e_src  = e_sum[RW-1:0];
		end else begin
			e_copy = !e_blank_q && ({1'b0, e_r_q} >= {1'b0, e_top_q} + {1'b0, e_n_q});
			e_src  = e_r_q - e_n_q;
		end
		e_last_c = (e_c_q == e_right_q);
		e_last_r = e_up_q ? (e_r_q == e_bot_q) : (e_r_q == e_top_q);
	end

	// teletype step decode
	logic put_lf_scroll;
	assign put_lf_scroll = (ch_q == tcce_pkg::CH_LF) && (cr_q == ROW_LAST);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			tcce_pkg::ST_CLEAR:
				if (clr_q == ADDR_W'(DEPTH - 1))
					st_d = tcce_pkg::ST_IDLE;
			tcce_pkg::ST_IDLE:
				if (accept) begin
					case (cmd_in.cmd)
						tcce_pkg::CMD_TTY, tcce_pkg::CMD_REP_STAY, tcce_pkg::CMD_REP_MOVE:
							st_d = tcce_pkg::ST_PUT;
						tcce_pkg::CMD_READ:
							st_d = tcce_pkg::ST_RD;
						tcce_pkg::CMD_SC_UP, tcce_pkg::CMD_SC_DOWN:
							st_d = w_empty ? tcce_pkg::ST_DONE : tcce_pkg::ST_SC_CELL;
						default:
							st_d = tcce_pkg::ST_DONE;
					endcase
				end
			tcce_pkg::ST_PUT:
				if (cnt_q == '0)
					st_d = tcce_pkg::ST_DONE;
				else if (put_lf_scroll)
					st_d = tcce_pkg::ST_SC_CELL;
			tcce_pkg::ST_SC_CELL, tcce_pkg::ST_SC_WR:
				if (st_q == tcce_pkg::ST_SC_CELL && e_copy)
					st_d = tcce_pkg::ST_SC_WR;
				else if (e_last_c && e_last_r)
					st_d = e_ret_q ? tcce_pkg::ST_PUT : tcce_pkg::ST_DONE;
				else
					st_d = tcce_pkg::ST_SC_CELL;
			tcce_pkg::ST_RD:   st_d = tcce_pkg::ST_RD_W;
			tcce_pkg::ST_RD_W: st_d = tcce_pkg::ST_DONE;
			tcce_pkg::ST_DONE:
				if (load_out)
					st_d = tcce_pkg::ST_IDLE;
			default: st_d = tcce_pkg::ST_IDLE;
		endcase
	end

	// store port control
	always_comb begin
		mem_we = 1'b0;
		mem_wa = cell_addr(e_pg_q, e_r_q, e_c_q);
		mem_wd = e_fill_q;
		mem_ra = cell_addr(e_pg_q, e_src, e_c_q);
		case (st_q)
			tcce_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = '0;
			end
			tcce_pkg::ST_PUT: begin
				mem_we = (cnt_q != '0) && (ch_q != tcce_pkg::CH_BELL) &&
					(ch_q != tcce_pkg::CH_BS) && (ch_q != tcce_pkg::CH_LF) &&
					(ch_q != tcce_pkg::CH_CR);
				mem_wa = cell_addr(pg_q, cr_q, cc_q);
				mem_wd = {at_q, ch_q};
			end
			tcce_pkg::ST_SC_CELL:
				mem_we = !e_copy;
			tcce_pkg::ST_SC_WR: begin
				mem_we = 1'b1;
				mem_wd = mem_rd_q;
			end
			tcce_pkg::ST_RD:
				mem_ra = cell_addr(pg_q, row_q[pg_q], col_q[pg_q]);
			default: ;
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= tcce_pkg::ST_CLEAR;
			clr_q     <= '0;
			o_valid_q <= 1'b0;
			for (int i = 0; i < PAGES; i++) begin
				row_q[i] <= (i == 0) ? ROW_RST : '0;
				col_q[i] <= '0;
			end
		end else begin
			st_q <= st_d;
			if (st_q == tcce_pkg::ST_CLEAR)
				clr_q <= clr_q + ADDR_W'(1);
			if (load_out)
				o_valid_q <= 1'b1;
			else if (res_out.ready)
				o_valid_q <= 1'b0;

			case (st_q)
				tcce_pkg::ST_IDLE:
					if (accept && cmd_in.cmd == tcce_pkg::CMD_SET_CUR) begin
						row_q[page_sel(cmd_in.page)] <= (cmd_in.cur_row > ROW_LAST) ?
							ROW_LAST : cmd_in.cur_row;
						col_q[page_sel(cmd_in.page)] <= ({1'b0, cmd_in.cur_col} > ec_m1) ?
							ec_m1[CW-1:0] : cmd_in.cur_col;
					end
				tcce_pkg::ST_PUT:
					if (cnt_q == '0 && move_q) begin
						row_q[pg_q] <= cr_q;
						col_q[pg_q] <= cc_q;
					end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (st_q)
			tcce_pkg::ST_IDLE:
				if (accept) begin
					cmd_q  <= cmd_in.cmd;
					pg_q   <= page_sel(cmd_in.page);
					ch_q   <= cmd_in.char_code;
					at_q   <= (cmd_in.cmd == tcce_pkg::CMD_REP_MOVE) ?
						tcce_pkg::ATTR_REP : cmd_in.attr;
					cnt_q  <= (cmd_in.cmd == tcce_pkg::CMD_TTY) ?
						tcce_pkg::CNT_W'(1) : cmd_in.count;
					move_q <= (cmd_in.cmd != tcce_pkg::CMD_REP_STAY);
					cr_q   <= row_q[page_sel(cmd_in.page)];
					cc_q   <= col_q[page_sel(cmd_in.page)];
					// window walk for the scroll commands
					e_pg_q    <= page_sel(act_page_q);
					e_up_q    <= (cmd_in.cmd == tcce_pkg::CMD_SC_UP);
					e_top_q   <= cmd_in.win_top;
					e_bot_q   <= w_bot;
					e_left_q  <= cmd_in.win_left;
					e_right_q <= w_right;
					e_c_q     <= cmd_in.win_left;
					e_r_q     <= (cmd_in.cmd == tcce_pkg::CMD_SC_UP) ? cmd_in.win_top : w_bot;
					e_n_q     <= cmd_in.scroll_lines[RW-1:0];
					e_blank_q <= w_blank;
					e_fill_q  <= {cmd_in.attr, tcce_pkg::CH_SPACE};
					e_ret_q   <= 1'b0;
				end
			tcce_pkg::ST_PUT:
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - tcce_pkg::CNT_W'(1);
					case (ch_q)
						tcce_pkg::CH_BELL: ;
						tcce_pkg::CH_BS:
							if (cc_q != '0)
								cc_q <= cc_q - CW'(1);
							else if (cr_q != '0) begin
								cc_q <= ec_m1[CW-1:0];
								cr_q <= cr_q - RW'(1);
							end
						tcce_pkg::CH_CR:
							cc_q <= '0;
						tcce_pkg::CH_LF:
							if (!put_lf_scroll)
								cr_q <= cr_q + RW'(1);
							else begin
								// whole page up one row, last row zeroed
								e_pg_q    <= pg_q;
								e_up_q    <= 1'b1;
								e_top_q   <= '0;
								e_bot_q   <= ROW_LAST;
								e_left_q  <= '0;
								e_right_q <= CW'(MAX_COLS - 1);
								e_c_q     <= '0;
								e_r_q     <= '0;
								e_n_q     <= RW'(1);
								e_blank_q <= (ROWS == 1);
								e_fill_q  <= '0;
								e_ret_q   <= 1'b1;
							end
						default:
							if ({1'b0, cc_q} + (CW + 1)'(1) < ec)
								cc_q <= cc_q + CW'(1);
							else if (cr_q != ROW_LAST) begin
								cc_q <= '0;
								cr_q <= cr_q + RW'(1);
							end
					endcase
				end
			tcce_pkg::ST_SC_CELL, tcce_pkg::ST_SC_WR:
				if (!(st_q == tcce_pkg::ST_SC_CELL && e_copy)) begin
					if (e_last_c) begin
						e_c_q <= e_left_q;
						if (!e_last_r)
							e_r_q <= e_up_q ? e_r_q + RW'(1) : e_r_q - RW'(1);
					end else
						e_c_q <= e_c_q + CW'(1);
				end
			tcce_pkg::ST_RD_W: begin
				rd_ch_q <= mem_rd_q[7:0];
				rd_at_q <= mem_rd_q[15:8];
			end
			default: ;
		endcase

		if (load_out) begin
			o_row_q  <= row_q[pg_q];
			o_col_q  <= col_q[pg_q];
			o_char_q <= (cmd_q == tcce_pkg::CMD_READ) ? rd_ch_q : '0;
			o_attr_q <= (cmd_q == tcce_pkg::CMD_READ) ? rd_at_q : '0;
		end
	end

	assign res_out.valid    = o_valid_q;
	assign res_out.out_row  = o_row_q;
	assign res_out.out_col  = o_col_q;
	assign res_out.out_char = o_char_q;
	assign res_out.out_attr = o_attr_q;
endmodule

FILE: design/tcce_checker.sv
// Port-level checks of the text console cell engine, bound to the top level.
`timescale 1ns / 1ps
module tcce_checker #(
	parameter int ROWS     = tcce_pkg::ROWS_DEF,
	parameter int MAX_COLS = tcce_pkg::MAX_COLS_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic [tcce_pkg::ROW_W-1:0]  res_row,
	input logic [tcce_pkg::COL_W-1:0]  res_col,
	input logic                        cmd_ready,
	input logic                        cfg_ready
);
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_row) && $stable(res_col))
		else $error("result beat dropped or changed while stalled");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ({1'b0, res_row} < (tcce_pkg::ROW_W + 1)'(ROWS)))
		else $error("cursor row beyond page");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ({1'b0, res_col} < (tcce_pkg::COL_W + 1)'(MAX_COLS)))
		else $error("cursor column beyond store row");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("register port stalled");

	a_no_take_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !cmd_ready)
		else $error("command taken before store cleared");
endmodule

bind text_console_cell_engine tcce_checker #(
	.ROWS(ROWS),
	.MAX_COLS(MAX_COLS)
) u_tcce_checker (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(res_out.valid),
	.res_ready(res_out.ready),
	.res_row(res_out.out_row),
	.res_col(res_out.out_col),
	.cmd_ready(cmd_in.ready),
	.cfg_ready(cfg.ready)
);
